// ===== hdl/tsnf_pkg.sv =====
// Shared types, constants and helpers of the tone stack nodal filter.
// Used by tsnf_alu and tone_stack_nodal_filter_top; depends on nothing.
package tsnf_pkg;

   localparam int VAL_W = 48;
   localparam int SAMPLE_W = 24;
   localparam int OHM_W = 20;
   localparam int CSR_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int SHIFT_W = 6;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [VAL_W-1:0] umag_type;
   typedef logic signed [VAL_W+3:0] wide_type;

   // Largest positive value and the magnitude bound of the 48-bit range
   localparam val_type VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam val_type VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam umag_type TOP47 = {1'b1, {(VAL_W-1){1'b0}}};

   // One siemens in units of 2^-8 nS
   localparam logic [VAL_W-1:0] SIEMENS = 48'd256000000000;

   // Default resistor values in ohms
   localparam int DEF_SLOPE_RES = 100000;
   localparam int DEF_TREBLE_POT_RES = 250000;
   localparam int DEF_BASS_POT_RES = 250000;
   localparam int DEF_MID_POT_RES = 10000;

   // Request to the shared arithmetic unit
   typedef struct packed {
      logic                start;
      logic                is_div;
      logic [SHIFT_W-1:0]  shift;
   } alu_req_type;

   // Magnitude of a 48-bit signed value
   function automatic umag_type mag48(input val_type x);
      mag48 = x[VAL_W-1] ? umag_type'(-x) : umag_type'(x);
   endfunction

   // Sign-extend to the wide sum type
   function automatic wide_type sx(input val_type x);
      sx = {{4{x[VAL_W-1]}}, x};
   endfunction

   // Clamp a wide sum to the 48-bit signed range
   function automatic val_type sat48(input wide_type x);
      if (x > sx(VAL_MAX)) begin
         sat48 = VAL_MAX;
      end else if (x < sx(VAL_MIN)) begin
         sat48 = VAL_MIN;
      end else begin
         sat48 = x[VAL_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/tsnf_alu.sv =====
// Shared multiply / divide unit of the tone stack nodal filter.
// Depends on tsnf_pkg. Multiply: four 24x24 partial products; divide: one bit a cycle.
module tsnf_alu
   import tsnf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type req,
   input  val_type     opa,
   input  val_type     opb,
   output logic        done,
   output val_type     result
);

   localparam int CNT_W = 7;
   localparam int HALF = VAL_W / 2;

   logic                busy_ff, busy_in;
   logic                is_div_ff, is_div_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   umag_type            ua_ff, ua_in;
   umag_type            ub_ff, ub_in;
   logic                neg_ff, neg_in;
   logic [SHIFT_W-1:0]  sh_ff, sh_in;
   logic [2*VAL_W-1:0]  prod_ff, prod_in;
   umag_type            rem_ff, rem_in;
   umag_type            dsr_ff, dsr_in;
   logic [VAL_W:0]      q_ff, q_in;
   logic                ovf_ff, ovf_in;
   logic                done_ff, done_in;
   val_type             res_ff, res_in;

   logic [HALF-1:0]     xa, xb;
   logic [VAL_W-1:0]    pp;
   logic [2*VAL_W-1:0]  pp_ext, shifted;
   logic [VAL_W:0]      rt;
   logic                ge;
   logic [CNT_W-1:0]    limit;
   umag_type            m;

   assign done = done_ff;
   assign result = res_ff;

   // Partial product select for the current multiply step
   always_comb begin
      xa = (cnt_ff[0]) ? ua_ff[VAL_W-1:HALF] : ua_ff[HALF-1:0];
      xb = (cnt_ff[1]) ? ub_ff[VAL_W-1:HALF] : ub_ff[HALF-1:0];
      pp = xa * xb;
      unique case (cnt_ff[1:0])
         2'd0: pp_ext = {{VAL_W{1'b0}}, pp};
         2'd3: pp_ext = {pp, {VAL_W{1'b0}}};
         default: pp_ext = {{HALF{1'b0}}, pp, {HALF{1'b0}}};
      endcase
      shifted = prod_ff >> sh_ff;
      rt = {rem_ff, dsr_ff[VAL_W-1]};
      ge = (rt >= {1'b0, ub_ff});
      limit = is_div_ff ? (CNT_W'(VAL_W) + CNT_W'(sh_ff)) : CNT_W'(4);
   end

   always_comb begin
      busy_in = busy_ff;
      is_div_in = is_div_ff;
      cnt_in = cnt_ff;
      ua_in = ua_ff;
      ub_in = ub_ff;
      neg_in = neg_ff;
      sh_in = sh_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      q_in = q_ff;
      ovf_in = ovf_ff;
      done_in = 1'b0;
      res_in = res_ff;
      m = '0;
      if (!busy_ff) begin
         // Latch operands on a start request
         if (req.start) begin
            busy_in = 1'b1;
            is_div_in = req.is_div;
            cnt_in = '0;
            ua_in = mag48(opa);
            ub_in = mag48(opb);
            neg_in = opa[VAL_W-1] ^ opb[VAL_W-1];
            sh_in = req.shift;
            prod_in = '0;
            rem_in = '0;
            dsr_in = mag48(opa);
            q_in = '0;
            ovf_in = 1'b0;
         end
      end else if (cnt_ff != limit) begin
         // Advance one step
         cnt_in = cnt_ff + CNT_W'(1);
         if (is_div_ff) begin
            dsr_in = {dsr_ff[VAL_W-2:0], 1'b0};
            rem_in = ge ? umag_type'(rt - {1'b0, ub_ff}) : rt[VAL_W-1:0];
            q_in = {q_ff[VAL_W-1:0], ge};
            ovf_in = ovf_ff | q_ff[VAL_W];
         end else begin
            prod_in = prod_ff + pp_ext;
         end
      end else begin
         // Saturate the magnitude and apply the sign
         if (is_div_ff) begin
            m = (ovf_ff || q_ff > {1'b0, TOP47}) ? TOP47 : q_ff[VAL_W-1:0];
         end else begin
            m = (|shifted[2*VAL_W-1:VAL_W-1]) ? TOP47 : {1'b0, shifted[VAL_W-2:0]};
         end
         if (neg_ff) begin
            res_in = val_type'(-m);
         end else begin
            res_in = (m == TOP47) ? VAL_MAX : val_type'(m);
         end
         done_in = 1'b1;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      is_div_ff <= is_div_in;
      cnt_ff <= cnt_in;
      ua_ff <= ua_in;
      ub_ff <= ub_in;
      neg_ff <= neg_in;
      sh_ff <= sh_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      q_ff <= q_in;
      ovf_ff <= ovf_in;
      res_ff <= res_in;
   end

endmodule

// ===== hdl/tone_stack_nodal_filter_top.sv =====
// Top level of the tone stack nodal filter: sequencer, matrix store and ports.
// Depends on tsnf_pkg and tsnf_alu.
//
//  channel  | direction | word
//  req_     | in        | tdata[23:0] sample_in
//  rsp_     | out       | tdata[23:0] sample_out
//  csr_     | in        | addr = register index, wdata = value
//
// A sample makes 27 products through the one shared multiplier. After reset or
// any register write the first sample first rebuilds and inverts the matrix,
// with bit-serial divides for the normalization. req_tready is high only while idle.
// A finished word waits in the output register; the block holds in its last step
// until the previous word has been taken.
module tone_stack_nodal_filter_top
   import tsnf_pkg::*;
#(
   parameter int SLOPE_RESISTANCE = DEF_SLOPE_RES,
   parameter int TREBLE_POT_RESISTANCE = DEF_TREBLE_POT_RES,
   parameter int BASS_POT_RESISTANCE = DEF_BASS_POT_RES,
   parameter int MID_POT_RESISTANCE = DEF_MID_POT_RES
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [23:0] sample_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,   // [23:0] sample_out
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int N = 5;
   localparam int NN = N * N;
   localparam int IX_W = $clog2(NN);
   localparam int DEN_W = 30;

   localparam val_type G_SLOPE = val_type'(SIEMENS / SLOPE_RESISTANCE);
   localparam logic [OHM_W-1:0] TRE_OHMS = OHM_W'(TREBLE_POT_RESISTANCE);
   localparam logic [OHM_W-1:0] BASS_OHMS = OHM_W'(BASS_POT_RESISTANCE);
   localparam logic [OHM_W-1:0] MID_OHMS = OHM_W'(MID_POT_RESISTANCE);
   localparam val_type ONE_Q40 = val_type'(1) <<< 40;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] R_BASS = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] R_MID = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] R_TREBLE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] R_SRC = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] R_CAP_T = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] R_CAP_B = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] R_CAP_M = 3'd6;

   // Shift amounts of the products and quotients
   localparam logic [SHIFT_W-1:0] SH_0 = 6'd0;
   localparam logic [SHIFT_W-1:0] SH_POT = 6'd10;
   localparam logic [SHIFT_W-1:0] SH_SRC = 6'd19;
   localparam logic [SHIFT_W-1:0] SH_INV = 6'd22;
   localparam logic [SHIFT_W-1:0] SH_SOLVE = 6'd26;
   localparam logic [SHIFT_W-1:0] SH_CAP = 6'd36;
   localparam logic [SHIFT_W-1:0] SH_Q40 = 6'd40;

   // Sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_GDIV = 5'd1;
   localparam logic [4:0] S_GWAIT = 5'd2;
   localparam logic [4:0] S_BUILD = 5'd3;
   localparam logic [4:0] S_PIV_INIT = 5'd4;
   localparam logic [4:0] S_PIV_SCAN = 5'd5;
   localparam logic [4:0] S_SWAP = 5'd6;
   localparam logic [4:0] S_NORM_D = 5'd7;
   localparam logic [4:0] S_NORM_A = 5'd8;
   localparam logic [4:0] S_NORM_AW = 5'd9;
   localparam logic [4:0] S_NORM_E = 5'd10;
   localparam logic [4:0] S_NORM_EW = 5'd11;
   localparam logic [4:0] S_ELIM_ROW = 5'd12;
   localparam logic [4:0] S_EA = 5'd13;
   localparam logic [4:0] S_EAW = 5'd14;
   localparam logic [4:0] S_EE = 5'd15;
   localparam logic [4:0] S_EEW = 5'd16;
   localparam logic [4:0] S_ELIM_NEXT = 5'd17;
   localparam logic [4:0] S_IEQ = 5'd18;
   localparam logic [4:0] S_IEQW = 5'd19;
   localparam logic [4:0] S_B0 = 5'd20;
   localparam logic [4:0] S_B0W = 5'd21;
   localparam logic [4:0] S_VM = 5'd22;
   localparam logic [4:0] S_VMW = 5'd23;
   localparam logic [4:0] S_UPD = 5'd24;
   localparam logic [4:0] S_UPDW = 5'd25;
   localparam logic [4:0] S_OUT = 5'd26;

   localparam logic [2:0] LAST = 3'd4;

   // Flat index of a matrix entry
   function automatic logic [IX_W-1:0] ix(input logic [2:0] row, input logic [2:0] col);
      ix = IX_W'({2'b0, row}) * IX_W'(N) + IX_W'({2'b0, col});
   endfunction

   // Knob clamped to at least one step
   function automatic logic [9:0] knob(input logic [9:0] p);
      knob = (p == 10'd0) ? 10'd1 : p;
   endfunction

   logic [4:0]            state_ff, state_in;
   logic                  stale_ff, stale_in;
   logic [9:0]            bass_ff, bass_in, mid_ff, mid_in, treble_ff, treble_in;
   logic [OHM_W-1:0]      src_ff, src_in;
   logic [CSR_W-1:0]      capc_ff [3];
   logic [CSR_W-1:0]      capc_in [3];
   val_type               a_ff [NN];
   val_type               a_in [NN];
   val_type               e_ff [NN];
   val_type               e_in [NN];
   logic [2:0]            perm_ff [N];
   logic [2:0]            perm_in [N];
   val_type               g_ff [N];
   val_type               g_in [N];
   val_type               cap_v_ff [3];
   val_type               cap_v_in [3];
   val_type               cap_i_ff [3];
   val_type               cap_i_in [3];
   val_type               ieq_ff [3];
   val_type               ieq_in [3];
   val_type               b_ff [4];
   val_type               b_in [4];
   val_type               v_ff [N];
   val_type               v_in [N];
   wide_type              acc_ff, acc_in;
   logic [2:0]            c_ff, c_in, r_ff, r_in, j_ff, j_in, p_ff, p_in, k_ff, k_in;
   logic [2:0]            pc_ff, pc_in, pr_ff, pr_in, pcold_ff, pcold_in;
   umag_type              best_ff, best_in;
   val_type               d_ff, d_in, f_ff, f_in;
   logic [SAMPLE_W-1:0]   vs_ff, vs_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_data_ff, rsp_data_in;

   alu_req_type           alu_req;
   val_type               alu_a, alu_b, alu_res;
   logic                  alu_done;

   logic [2:0]            perm_ra;
   logic [2:0]            perm_rd;
   logic [IX_W-1:0]       a_ra, e_ra;
   val_type               a_rd, e_rd;
   val_type               capg [3];
   val_type               vn [3];
   logic [9:0]            steps;
   logic [OHM_W-1:0]      ohms;
   logic [DEN_W-1:0]      den_prod;
   val_type               den;
   wide_type              sum;
   logic signed [VAL_W:0] qround;
   logic signed [31:0]    qs;
   logic [SAMPLE_W-1:0]   qsat;

   tsnf_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .opa    (alu_a),
      .opb    (alu_b),
      .done   (alu_done),
      .result (alu_res)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // Read ports of the row map and both matrices
   assign perm_rd = perm_ff[perm_ra];
   assign a_rd = a_ff[a_ra];
   assign e_rd = e_ff[e_ra];

   // Companion conductances, node voltage differences, output rounding
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         capg[i] = val_type'({capc_ff[i], 8'b0});
      end
      vn[0] = sat48(sx(v_ff[0]) - sx(v_ff[1]));
      vn[1] = sat48(sx(v_ff[2]) - sx(v_ff[3]));
      vn[2] = v_ff[3];
      qround = {v_ff[4][VAL_W-1], v_ff[4]} + (VAL_W+1)'(65536);
      qs = qround[VAL_W:17];
      if (qs > 32'sd8388607) begin
         qsat = 24'h7FFFFF;
      end else if (qs < -32'sd8388608) begin
         qsat = 24'h800000;
      end else begin
         qsat = qs[SAMPLE_W-1:0];
      end
   end

   // Pot and source divisors
   always_comb begin
      unique case (k_ff)
         3'd1: begin
            steps = 10'(11'd1024 - {1'b0, knob(treble_ff)});
            ohms = TRE_OHMS;
         end
         3'd2: begin
            steps = knob(treble_ff);
            ohms = TRE_OHMS;
         end
         3'd3: begin
            steps = knob(bass_ff);
            ohms = BASS_OHMS;
         end
         default: begin
            steps = knob(mid_ff);
            ohms = MID_OHMS;
         end
      endcase
      den_prod = DEN_W'(steps) * DEN_W'(ohms);
      if (k_ff == 3'd0) begin
         den = val_type'((src_ff == '0) ? OHM_W'(1) : src_ff);
      end else begin
         den = val_type'((den_prod < DEN_W'(1024)) ? DEN_W'(1024) : den_prod);
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      stale_in = stale_ff;
      bass_in = bass_ff;
      mid_in = mid_ff;
      treble_in = treble_ff;
      src_in = src_ff;
      capc_in = capc_ff;
      a_in = a_ff;
      e_in = e_ff;
      perm_in = perm_ff;
      g_in = g_ff;
      cap_v_in = cap_v_ff;
      cap_i_in = cap_i_ff;
      ieq_in = ieq_ff;
      b_in = b_ff;
      v_in = v_ff;
      acc_in = acc_ff;
      c_in = c_ff;
      r_in = r_ff;
      j_in = j_ff;
      p_in = p_ff;
      k_in = k_ff;
      pc_in = pc_ff;
      pr_in = pr_ff;
      pcold_in = pcold_ff;
      best_in = best_ff;
      d_in = d_ff;
      f_in = f_ff;
      vs_in = vs_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      alu_req = '0;
      alu_a = '0;
      alu_b = '0;
      perm_ra = r_ff;
      a_ra = ix(pc_ff, j_ff);
      e_ra = ix(pc_ff, j_ff);
      sum = '0;

      // Drop the output word once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               vs_in = req_tdata;
               k_in = '0;
               state_in = stale_ff ? S_GDIV : S_IEQ;
            end
         end
         // Resistor and pot conductances by division
         S_GDIV: begin
            alu_req = '{start: 1'b1, is_div: 1'b1, shift: (k_ff == 3'd0) ? SH_0 : SH_POT};
            alu_a = val_type'(SIEMENS);
            alu_b = den;
            state_in = S_GWAIT;
         end
         S_GWAIT: begin
            if (alu_done) begin
               g_in[k_ff] = alu_res;
               if (k_ff == LAST) begin
                  state_in = S_BUILD;
               end else begin
                  k_in = k_ff + 3'd1;
                  state_in = S_GDIV;
               end
            end
         end
         // Load the nodal matrix, identity and row map
         S_BUILD: begin
            for (int i = 0; i < NN; i++) begin
               a_in[i] = '0;
               e_in[i] = ((i % N) == (i / N)) ? ONE_Q40 : '0;
            end
            for (int i = 0; i < N; i++) begin
               perm_in[i] = 3'(i);
            end
            a_in[ix(3'd0, 3'd0)] = g_ff[0] + capg[0] + G_SLOPE;
            a_in[ix(3'd0, 3'd1)] = -capg[0];
            a_in[ix(3'd1, 3'd0)] = -capg[0];
            a_in[ix(3'd0, 3'd2)] = -G_SLOPE;
            a_in[ix(3'd2, 3'd0)] = -G_SLOPE;
            a_in[ix(3'd1, 3'd1)] = capg[0] + g_ff[1];
            a_in[ix(3'd1, 3'd4)] = -g_ff[1];
            a_in[ix(3'd4, 3'd1)] = -g_ff[1];
            a_in[ix(3'd4, 3'd4)] = g_ff[1] + g_ff[2];
            a_in[ix(3'd2, 3'd4)] = -g_ff[2];
            a_in[ix(3'd4, 3'd2)] = -g_ff[2];
            a_in[ix(3'd2, 3'd2)] = G_SLOPE + g_ff[2] + g_ff[3] + capg[1];
            a_in[ix(3'd2, 3'd3)] = -(g_ff[3] + capg[1]);
            a_in[ix(3'd3, 3'd2)] = -(g_ff[3] + capg[1]);
            a_in[ix(3'd3, 3'd3)] = g_ff[3] + capg[1] + g_ff[4] + capg[2];
            c_in = '0;
            state_in = S_PIV_INIT;
         end
         // Pivot search down the column
         S_PIV_INIT: begin
            perm_ra = c_ff;
            a_ra = ix(perm_rd, c_ff);
            pcold_in = perm_rd;
            p_in = c_ff;
            best_in = mag48(a_rd);
            r_in = c_ff + 3'd1;
            state_in = (c_ff == LAST) ? S_NORM_D : S_PIV_SCAN;
         end
         S_PIV_SCAN: begin
            perm_ra = r_ff;
            a_ra = ix(perm_rd, c_ff);
            if (mag48(a_rd) > best_ff) begin
               best_in = mag48(a_rd);
               p_in = r_ff;
            end
            if (r_ff == LAST) begin
               state_in = S_SWAP;
            end else begin
               r_in = r_ff + 3'd1;
            end
         end
         S_SWAP: begin
            perm_ra = p_ff;
            perm_in[c_ff] = perm_rd;
            perm_in[p_ff] = pcold_ff;
            state_in = S_NORM_D;
         end
         S_NORM_D: begin
            perm_ra = c_ff;
            a_ra = ix(perm_rd, c_ff);
            pc_in = perm_rd;
            d_in = a_rd;
            j_in = '0;
            state_in = S_NORM_A;
         end
         // Divide the pivot row by the pivot, or clear it when the pivot is zero
         S_NORM_A: begin
            a_ra = ix(pc_ff, j_ff);
            if (d_ff == '0) begin
               a_in[ix(pc_ff, j_ff)] = '0;
               e_in[ix(pc_ff, j_ff)] = '0;
               if (j_ff == LAST) begin
                  r_in = '0;
                  state_in = S_ELIM_ROW;
               end else begin
                  j_in = j_ff + 3'd1;
               end
            end else begin
               alu_req = '{start: 1'b1, is_div: 1'b1, shift: SH_Q40};
               alu_a = a_rd;
               alu_b = d_ff;
               state_in = S_NORM_AW;
            end
         end
         S_NORM_AW: begin
            if (alu_done) begin
               a_in[ix(pc_ff, j_ff)] = alu_res;
               state_in = S_NORM_E;
            end
         end
         S_NORM_E: begin
            e_ra = ix(pc_ff, j_ff);
            alu_req = '{start: 1'b1, is_div: 1'b1, shift: SH_INV};
            alu_a = e_rd;
            alu_b = d_ff;
            state_in = S_NORM_EW;
         end
         S_NORM_EW: begin
            if (alu_done) begin
               e_in[ix(pc_ff, j_ff)] = alu_res;
               if (j_ff == LAST) begin
                  r_in = '0;
                  state_in = S_ELIM_ROW;
               end else begin
                  j_in = j_ff + 3'd1;
                  state_in = S_NORM_A;
               end
            end
         end
         // Eliminate the column from every other row
         S_ELIM_ROW: begin
            perm_ra = r_ff;
            a_ra = ix(perm_rd, c_ff);
            if (r_ff == c_ff) begin
               state_in = S_ELIM_NEXT;
            end else begin
               f_in = a_rd;
               pr_in = perm_rd;
               j_in = '0;
               state_in = S_EA;
            end
         end
         S_EA: begin
            a_ra = ix(pc_ff, j_ff);
            alu_req = '{start: 1'b1, is_div: 1'b0, shift: SH_Q40};
            alu_a = f_ff;
            alu_b = a_rd;
            state_in = S_EAW;
         end
         S_EAW: begin
            a_ra = ix(pr_ff, j_ff);
            if (alu_done) begin
               a_in[ix(pr_ff, j_ff)] = sat48(sx(a_rd) - sx(alu_res));
               state_in = S_EE;
            end
         end
         S_EE: begin
            e_ra = ix(pc_ff, j_ff);
            alu_req = '{start: 1'b1, is_div: 1'b0,
                        shift: (r_ff < c_ff) ? SH_Q40 : SH_INV};
            alu_a = f_ff;
            alu_b = e_rd;
            state_in = S_EEW;
         end
         S_EEW: begin
            e_ra = ix(pr_ff, j_ff);
            if (alu_done) begin
               e_in[ix(pr_ff, j_ff)] = sat48(sx(e_rd) - sx(alu_res));
               if (j_ff == LAST) begin
                  state_in = S_ELIM_NEXT;
               end else begin
                  j_in = j_ff + 3'd1;
                  state_in = S_EA;
               end
            end
         end
         S_ELIM_NEXT: begin
            if (r_ff != LAST) begin
               r_in = r_ff + 3'd1;
               state_in = S_ELIM_ROW;
            end else if (c_ff != LAST) begin
               c_in = c_ff + 3'd1;
               state_in = S_PIV_INIT;
            end else begin
               stale_in = 1'b0;
               k_in = '0;
               state_in = S_IEQ;
            end
         end
         // Capacitor history currents
         S_IEQ: begin
            alu_req = '{start: 1'b1, is_div: 1'b0, shift: SH_CAP};
            alu_a = capg[k_ff[1:0]];
            alu_b = cap_v_ff[k_ff[1:0]];
            state_in = S_IEQW;
         end
         S_IEQW: begin
            if (alu_done) begin
               ieq_in[k_ff[1:0]] = sat48(sx(alu_res) + sx(cap_i_ff[k_ff[1:0]]));
               if (k_ff == 3'd2) begin
                  state_in = S_B0;
               end else begin
                  k_in = k_ff + 3'd1;
                  state_in = S_IEQ;
               end
            end
         end
         // Current vector
         S_B0: begin
            alu_req = '{start: 1'b1, is_div: 1'b0, shift: SH_SRC};
            alu_a = g_ff[0];
            alu_b = val_type'(signed'(vs_ff));
            state_in = S_B0W;
         end
         S_B0W: begin
            if (alu_done) begin
               b_in[0] = sat48(sx(alu_res) + sx(ieq_ff[0]));
               b_in[1] = sat48(-sx(ieq_ff[0]));
               b_in[2] = ieq_ff[1];
               b_in[3] = sat48(sx(ieq_ff[2]) - sx(ieq_ff[1]));
               r_in = '0;
               j_in = '0;
               acc_in = '0;
               state_in = S_VM;
            end
         end
         // Node voltages: inverse times current vector, last source is zero
         S_VM: begin
            perm_ra = r_ff;
            e_ra = ix(perm_rd, j_ff);
            alu_req = '{start: 1'b1, is_div: 1'b0, shift: SH_SOLVE};
            alu_a = e_rd;
            alu_b = b_ff[j_ff[1:0]];
            state_in = S_VMW;
         end
         S_VMW: begin
            if (alu_done) begin
               sum = acc_ff + sx(alu_res);
               if (j_ff == 3'd3) begin
                  v_in[r_ff] = sat48(sum);
                  acc_in = '0;
                  j_in = '0;
                  if (r_ff == LAST) begin
                     k_in = '0;
                     state_in = S_UPD;
                  end else begin
                     r_in = r_ff + 3'd1;
                     state_in = S_VM;
                  end
               end else begin
                  acc_in = sum;
                  j_in = j_ff + 3'd1;
                  state_in = S_VM;
               end
            end
         end
         // Capacitor state update
         S_UPD: begin
            alu_req = '{start: 1'b1, is_div: 1'b0, shift: SH_CAP};
            alu_a = capg[k_ff[1:0]];
            alu_b = vn[k_ff[1:0]];
            state_in = S_UPDW;
         end
         S_UPDW: begin
            if (alu_done) begin
               cap_i_in[k_ff[1:0]] = sat48(sx(alu_res) - sx(ieq_ff[k_ff[1:0]]));
               cap_v_in[k_ff[1:0]] = vn[k_ff[1:0]];
               if (k_ff == 3'd2) begin
                  state_in = S_OUT;
               end else begin
                  k_in = k_ff + 3'd1;
                  state_in = S_UPD;
               end
            end
         end
         // Hold until the output register is free
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = qsat;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register writes mark the matrix stale
      if (csr_we) begin
         unique case (csr_addr)
            R_BASS: bass_in = csr_wdata[9:0];
            R_MID: mid_in = csr_wdata[9:0];
            R_TREBLE: treble_in = csr_wdata[9:0];
            R_SRC: src_in = csr_wdata[OHM_W-1:0];
            R_CAP_T: capc_in[0] = csr_wdata;
            R_CAP_B: capc_in[1] = csr_wdata;
            R_CAP_M: capc_in[2] = csr_wdata;
            default: ;
         endcase
         if (csr_addr <= R_CAP_M) begin
            stale_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stale_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         bass_ff <= 10'd512;
         mid_ff <= 10'd512;
         treble_ff <= 10'd512;
         src_ff <= 20'd60000;
         capc_ff[0] <= 32'd24000;
         capc_ff[1] <= 32'd9600000;
         capc_ff[2] <= 32'd2000000;
         for (int i = 0; i < 3; i++) begin
            cap_v_ff[i] <= '0;
            cap_i_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         stale_ff <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
         bass_ff <= bass_in;
         mid_ff <= mid_in;
         treble_ff <= treble_in;
         src_ff <= src_in;
         capc_ff <= capc_in;
         cap_v_ff <= cap_v_in;
         cap_i_ff <= cap_i_in;
      end
      a_ff <= a_in;
      e_ff <= e_in;
      perm_ff <= perm_in;
      g_ff <= g_in;
      ieq_ff <= ieq_in;
      b_ff <= b_in;
      v_ff <= v_in;
      acc_ff <= acc_in;
      c_ff <= c_in;
      r_ff <= r_in;
      j_ff <= j_in;
      p_ff <= p_in;
      k_ff <= k_in;
      pc_ff <= pc_in;
      pr_ff <= pr_in;
      pcold_ff <= pcold_in;
      best_ff <= best_in;
      d_ff <= d_in;
      f_ff <= f_in;
      vs_ff <= vs_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
